### rtl/afpa_pkg.sv
package afpa_pkg;

  localparam int MAX_ENTRIES_DEF = 8;
  localparam int ID_BITS_DEF     = 16;

  localparam logic [2:0] CMD_GAIN       = 3'd0;
  localparam logic [2:0] CMD_GAIN_TRANS = 3'd1;
  localparam logic [2:0] CMD_GAIN_DUCK  = 3'd2;
  localparam logic [2:0] CMD_ABANDON    = 3'd3;
  localparam logic [2:0] CMD_Q_STATE    = 3'd4;
  localparam logic [2:0] CMD_Q_CURRENT  = 3'd5;

  localparam logic [2:0] RK_NOTIFY    = 3'd0;
  localparam logic [2:0] RK_BROADCAST = 3'd1;
  localparam logic [2:0] RK_STATE     = 3'd2;
  localparam logic [2:0] RK_CURRENT   = 3'd3;
  localparam logic [2:0] RK_DONE      = 3'd4;

  localparam logic [2:0] CC_LOSS       = 3'd3;
  localparam logic [2:0] CC_LOSS_TRANS = 3'd4;
  localparam logic [2:0] CC_LOSS_DUCK  = 3'd5;

  localparam logic [1:0] KIND_TRANS = 2'd1;
  localparam logic [1:0] KIND_DUCK  = 2'd2;

  localparam logic [1:0] ANS_RELEASED = 2'd0;
  localparam logic [1:0] ANS_ACQUIRED = 2'd1;
  localparam logic [1:0] ANS_DUCKED   = 2'd2;

  localparam logic [1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [1:0] REG_BAND_HIGH = 2'd1;
  localparam logic [1:0] REG_IDLE_POL  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [3:0] key_pol;
    logic [1:0] new_kind;
    logic [3:0] band_lo;
    logic [3:0] band_hi;
  } cell_ctl_t;

  // new policy pa ties or beats stored policy pb
  function automatic logic goes_before(input logic [3:0] pa, input logic [3:0] pb,
                                       input logic [3:0] lo, input logic [3:0] hi);
    logic ba, bb;
    ba = (pa > lo) && (pa <= hi);
    bb = (pb > lo) && (pb <= hi);
    return (ba && bb) || (pa >= pb);
  endfunction

endpackage

### rtl/afpa_cell.sv
module afpa_cell
  import afpa_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [ID_BITS-1:0] key_id,
  input  logic               valid,
  input  logic               left_valid,
  input  logic               carry_in,
  output logic               carry_out,
  input  logic [ID_BITS-1:0] left_id,
  input  logic [3:0]         left_pol,
  input  logic [1:0]         left_kind,
  input  logic [ID_BITS-1:0] right_id,
  input  logic [3:0]         right_pol,
  input  logic [1:0]         right_kind,
  output logic [ID_BITS-1:0] id_q,
  output logic [3:0]         pol_q,
  output logic [1:0]         kind_q
);

  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [3:0]         pol_r, pol_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic               trig;

  always_comb begin
    trig = 1'b0;
    case (ctl.op)
      OP_INSERT: trig = valid ? goes_before(ctl.key_pol, pol_r, ctl.band_lo, ctl.band_hi)
                              : left_valid;
      OP_REMOVE: trig = valid && (id_r == key_id);
      default:   trig = 1'b0;
    endcase
  end

  assign carry_out = carry_in | trig;

  always_comb begin
    id_nxt   = id_r;
    pol_nxt  = pol_r;
    kind_nxt = kind_r;
    case (ctl.op)
      OP_INSERT: begin
        if (carry_in) begin
          id_nxt = left_id; pol_nxt = left_pol; kind_nxt = left_kind;
        end else if (trig) begin
          id_nxt = key_id; pol_nxt = ctl.key_pol; kind_nxt = ctl.new_kind;
        end
      end
      OP_REMOVE: begin
        if (carry_out) begin
          id_nxt = right_id; pol_nxt = right_pol; kind_nxt = right_kind;
        end
      end
      OP_POP: begin
        id_nxt = right_id; pol_nxt = right_pol; kind_nxt = right_kind;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    pol_r  <= pol_nxt;
    kind_r <= kind_nxt;
  end

  assign id_q   = id_r;
  assign pol_q  = pol_r;
  assign kind_q = kind_r;

endmodule

### rtl/audio_focus_priority_arbiter_top.sv
// Audio focus arbiter with ducking.
// Input channel (in_valid/in_stall) takes one command word: gain, gain
// transient, gain may duck, abandon, or one of two queries. The result
// channel (out_valid/out_stall) returns one to four words per command;
// out_last marks the final one and out_overflow is set on every word of a
// request that met a full list; its lowest entry or the new one falls off.
// Configuration (cfg_we/cfg_index/cfg_data) sets the always-tie band and
// the idle policy; write only while the block is idle.
// One command at a time: in_stall is high from acceptance until the last
// result word is taken. Queries, a request on an empty list and a head
// re-request go from S_PREP straight to the result words; a head abandon
// passes S_ABAND first, a non-head abandon passes S_REMOVE, where the cell
// chain removes the list entries carrying that stream id one match per
// cycle, and a request that walks the insert passes S_REMOVE, then S_REQ.
// Result words then go out one per cycle while out_stall is low; the result
// word holds while stalled.
// Reset empties the list, clears the ducked stream, loads band low 0 and
// band high 8 (policies 1..8 tie) and idle policy 1.
module audio_focus_priority_arbiter_top
  import afpa_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [ID_BITS-1:0] in_stream_id,
  input  logic [3:0]         in_stream_policy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_result_kind,
  output logic [ID_BITS-1:0] out_target_id,
  output logic [2:0]         out_change_code,
  output logic [3:0]         out_broadcast_policy,
  output logic               out_skip_valid,
  output logic [ID_BITS-1:0] out_skip_id,
  output logic [1:0]         out_focus_answer,
  output logic               out_overflow,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREP   = 6'b000010,
    S_REMOVE = 6'b000100,
    S_REQ    = 6'b001000,
    S_ABAND  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [ID_BITS-1:0] target;
    logic [2:0]         code;
    logic [3:0]         pol;
    logic               skipv;
    logic [ID_BITS-1:0] skipid;
    logic [1:0]         ans;
  } res_t;

  function automatic res_t mk(input logic [2:0] k, input logic [ID_BITS-1:0] t,
                              input logic [2:0] c, input logic [3:0] p,
                              input logic sv, input logic [ID_BITS-1:0] sid,
                              input logic [1:0] a);
    res_t r;
    r.kind = k; r.target = t; r.code = c; r.pol = p;
    r.skipv = sv; r.skipid = sid; r.ans = a;
    return r;
  endfunction

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               dv_r, dv_nxt;
  logic [ID_BITS-1:0] did_r, did_nxt;
  logic [3:0]         band_lo_r, band_hi_r, idle_pol_r;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [3:0]         pol_r, pol_nxt;
  logic               ovf_r, ovf_nxt;
  res_t               buf_r [4];
  res_t               buf_nxt [4];
  logic [2:0]         rcnt_r, rcnt_nxt;
  logic [1:0]         idx_r, idx_nxt;

  cell_ctl_t          ctl;
  logic [MAX_ENTRIES:0] carry;
  logic [MAX_ENTRIES-1:0] cvalid;
  logic [ID_BITS-1:0] cid   [MAX_ENTRIES];
  logic [3:0]         cpol  [MAX_ENTRIES];
  logic [1:0]         ckind [MAX_ENTRIES];

  logic               in_acc, hit, full, is_req, gb0;
  logic [ID_BITS-1:0] head_id;
  logic [3:0]         head_pol;
  logic [1:0]         head_kind;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign hit       = carry[MAX_ENTRIES];
  assign full      = (count_r == CW'(MAX_ENTRIES));
  assign is_req    = cmd_r inside {CMD_GAIN, CMD_GAIN_TRANS, CMD_GAIN_DUCK};
  assign head_id   = cid[0];
  assign head_pol  = cpol[0];
  assign head_kind = ckind[0];
  assign gb0       = goes_before(pol_r, head_pol, band_lo_r, band_hi_r);
  assign carry[0]  = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      assign cvalid[g] = (CW'(g) < count_r);
      afpa_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .key_id     (id_r),
        .valid      (cvalid[g]),
        .left_valid ((g == 0) ? 1'b1 : cvalid[(g == 0) ? 0 : g - 1]),
        .carry_in   (carry[g]),
        .carry_out  (carry[g+1]),
        .left_id    (cid[(g == 0) ? 0 : g - 1]),
        .left_pol   (cpol[(g == 0) ? 0 : g - 1]),
        .left_kind  (ckind[(g == 0) ? 0 : g - 1]),
        .right_id   (cid[(g == MAX_ENTRIES - 1) ? g : g + 1]),
        .right_pol  (cpol[(g == MAX_ENTRIES - 1) ? g : g + 1]),
        .right_kind (ckind[(g == MAX_ENTRIES - 1) ? g : g + 1]),
        .id_q       (cid[g]),
        .pol_q      (cpol[g]),
        .kind_q     (ckind[g])
      );
    end
  endgenerate

  always_comb begin
    logic [2:0] n;
    state_nxt = state_r;
    count_nxt = count_r;
    dv_nxt    = dv_r;
    did_nxt   = did_r;
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    pol_nxt   = pol_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    for (int i = 0; i < 4; i++) buf_nxt[i] = buf_r[i];
    n = rcnt_r;
    ctl.op       = OP_HOLD;
    ctl.key_pol  = pol_r;
    ctl.new_kind = cmd_r[1:0];
    ctl.band_lo  = band_lo_r;
    ctl.band_hi  = band_hi_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_command;
          id_nxt    = in_stream_id;
          pol_nxt   = in_stream_policy;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        n = 3'd0;
        ovf_nxt = 1'b0;
        case (cmd_r)
          CMD_GAIN, CMD_GAIN_TRANS, CMD_GAIN_DUCK: begin
            if (count_r != '0 && head_id == id_r) begin
              state_nxt = S_EMIT;
            end else if (count_r == '0) begin
              ctl.op    = OP_INSERT;
              count_nxt = count_r + CW'(1);
              buf_nxt[n[1:0]] = mk(RK_NOTIFY, id_r, cmd_r, 4'd0, 1'b0, '0, 2'd0);
              n = n + 3'd1;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_REMOVE;
            end
          end
          CMD_ABANDON: begin
            if (count_r != '0 && head_id == id_r) begin
              ctl.op    = OP_POP;
              count_nxt = count_r - CW'(1);
              state_nxt = S_ABAND;
            end else begin
              state_nxt = S_REMOVE;
            end
          end
          CMD_Q_STATE: begin
            buf_nxt[n[1:0]] = mk(RK_STATE, '0, 3'd0, 4'd0, 1'b0, '0,
                                 (count_r == '0) ? ANS_RELEASED :
                                 (head_id == id_r) ? ANS_ACQUIRED :
                                 (dv_r && did_r == id_r) ? ANS_DUCKED : ANS_RELEASED);
            n = n + 3'd1;
            state_nxt = S_EMIT;
          end
          CMD_Q_CURRENT: begin
            if (count_r == '0)
              buf_nxt[n[1:0]] = mk(RK_CURRENT, '0, 3'd0, idle_pol_r, 1'b0, '0, 2'd0);
            else
              buf_nxt[n[1:0]] = mk(RK_CURRENT, head_id, 3'd0, head_pol, 1'b0, '0, 2'd0);
            n = n + 3'd1;
            state_nxt = S_EMIT;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_REMOVE: begin
        ctl.op = OP_REMOVE;
        if (hit) begin
          count_nxt = count_r - CW'(1);
        end else begin
          if (dv_r && did_r == id_r) dv_nxt = 1'b0;
          state_nxt = is_req ? S_REQ : S_EMIT;
        end
      end
      S_REQ: begin
        ctl.op    = OP_INSERT;
        ovf_nxt   = full;
        count_nxt = full ? count_r : count_r + CW'(1);
        if (gb0) begin
          if (!dv_r) begin
            if (cmd_r == CMD_GAIN_DUCK) begin
              buf_nxt[n[1:0]] = mk(RK_NOTIFY, head_id, CC_LOSS_DUCK, 4'd0, 1'b0, '0, 2'd0);
              dv_nxt  = 1'b1;
              did_nxt = head_id;
            end else begin
              buf_nxt[n[1:0]] = mk(RK_NOTIFY, head_id,
                                   (cmd_r == CMD_GAIN_TRANS) ? CC_LOSS_TRANS : CC_LOSS,
                                   4'd0, 1'b0, '0, 2'd0);
            end
            n = n + 3'd1;
          end else if (cmd_r == CMD_GAIN_DUCK) begin
            buf_nxt[n[1:0]] = mk(RK_NOTIFY, head_id, CC_LOSS_TRANS, 4'd0, 1'b0, '0, 2'd0);
            n = n + 3'd1;
          end else begin
            buf_nxt[n[1:0]] = mk(RK_NOTIFY, head_id,
                                 (cmd_r == CMD_GAIN_TRANS) ? CC_LOSS_TRANS : CC_LOSS,
                                 4'd0, 1'b0, '0, 2'd0);
            n = n + 3'd1;
            buf_nxt[n[1:0]] = mk(RK_NOTIFY, did_r, CC_LOSS, 4'd0, 1'b0, '0, 2'd0);
            n = n + 3'd1;
            dv_nxt = 1'b0;
          end
          buf_nxt[n[1:0]] = mk(RK_BROADCAST, '0, 3'd0, pol_r, dv_nxt,
                               dv_nxt ? did_nxt : '0, 2'd0);
          n = n + 3'd1;
          buf_nxt[n[1:0]] = mk(RK_NOTIFY, id_r, cmd_r, 4'd0, 1'b0, '0, 2'd0);
          n = n + 3'd1;
        end
        state_nxt = S_EMIT;
      end
      S_ABAND: begin
        if (count_r != '0) begin
          if (!dv_r || head_id == did_r) begin
            buf_nxt[n[1:0]] = mk(RK_NOTIFY, head_id, {1'b0, head_kind}, 4'd0,
                                 1'b0, '0, 2'd0);
            n = n + 3'd1;
            dv_nxt = 1'b0;
          end else begin
            if (head_kind != KIND_DUCK) begin
              buf_nxt[n[1:0]] = mk(RK_NOTIFY, did_r, CC_LOSS, 4'd0, 1'b0, '0, 2'd0);
              n = n + 3'd1;
              dv_nxt = 1'b0;
            end
            buf_nxt[n[1:0]] = mk(RK_BROADCAST, '0, 3'd0, pol_r, dv_nxt,
                                 dv_nxt ? did_r : '0, 2'd0);
            n = n + 3'd1;
            buf_nxt[n[1:0]] = mk(RK_NOTIFY, head_id, {1'b0, head_kind}, 4'd0,
                                 1'b0, '0, 2'd0);
            n = n + 3'd1;
          end
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          if ({1'b0, idx_r} == rcnt_r - 3'd1) begin
            idx_nxt   = 2'd0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // every command answers with at least one word
    if (state_nxt == S_EMIT && state_r != S_EMIT && n == 3'd0) begin
      buf_nxt[0] = mk(RK_DONE, '0, 3'd0, 4'd0, 1'b0, '0, 2'd0);
      n = 3'd1;
    end
    rcnt_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      dv_r       <= 1'b0;
      did_r      <= '0;
      band_lo_r  <= 4'd0;
      band_hi_r  <= 4'd8;
      idle_pol_r <= 4'd1;
      rcnt_r     <= 3'd0;
      idx_r      <= 2'd0;
      ovf_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      dv_r    <= dv_nxt;
      did_r   <= did_nxt;
      rcnt_r  <= rcnt_nxt;
      idx_r   <= idx_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_BAND_LOW:  band_lo_r  <= cfg_data;
          REG_BAND_HIGH: band_hi_r  <= cfg_data;
          REG_IDLE_POL:  idle_pol_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    id_r  <= id_nxt;
    pol_r <= pol_nxt;
    for (int i = 0; i < 4; i++) buf_r[i] <= buf_nxt[i];
  end

  assign out_valid            = (state_r == S_EMIT);
  assign out_result_kind      = buf_r[idx_r].kind;
  assign out_target_id        = buf_r[idx_r].target;
  assign out_change_code      = buf_r[idx_r].code;
  assign out_broadcast_policy = buf_r[idx_r].pol;
  assign out_skip_valid       = buf_r[idx_r].skipv;
  assign out_skip_id          = buf_r[idx_r].skipid;
  assign out_focus_answer     = buf_r[idx_r].ans;
  assign out_overflow         = ovf_r;
  assign out_last             = ({1'b0, idx_r} == rcnt_r - 3'd1);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond list depth");

  a_emit_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rcnt_r != 3'd0) && ({1'b0, idx_r} < rcnt_r))
    else $error("result word index outside buffer");

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_PREP) && !out_valid)
    else $error("accepted word did not start processing");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REMOVE) && hit |=> count_r == $past(count_r) - CW'(1))
    else $error("removal did not shrink the list");

endmodule

### bench/audio_focus_priority_arbiter_top_test.sv
`timescale 1ns / 1ps
module audio_focus_priority_arbiter_top_test;
  import afpa_pkg::*;

  localparam int DEPTH = 8;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] id;
    logic [3:0]  pol;
  } focus_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] target;
    logic [2:0]  code;
    logic [3:0]  bpol;
    logic        skv;
    logic [15:0] skid;
    logic [1:0]  ans;
    logic        ovf;
    logic        last;
  } focus_word_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [2:0] in_command = 0;
  logic [15:0] in_stream_id = 0;
  logic [3:0] in_stream_policy = 0;
  logic in_stall, out_valid;
  logic [2:0] out_result_kind, out_change_code;
  logic [15:0] out_target_id, out_skip_id;
  logic [3:0] out_broadcast_policy;
  logic out_skip_valid, out_overflow, out_last;
  logic [1:0] out_focus_answer;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [3:0] cfg_data = 0;

  audio_focus_priority_arbiter_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [15:0] st_id [DEPTH];
  logic [3:0]  st_pol [DEPTH];
  logic [1:0]  st_kind [DEPTH];
  int          st_cnt;
  logic        dk_v;
  logic [15:0] dk_id;
  logic [3:0]  band_lo = 0, band_hi = 8, idle_pol = 1;

  focus_req_t  pending_q[$];
  focus_word_t expected_q[$];
  focus_word_t batch[$];
  int errors = 0, accepted = 0, words_seen = 0, ovf_seen = 0;
  int hold_long = 0;
  bit drv_pause = 0;
  bit drain_wait = 0;

  function automatic bit tie_or_beat(logic [3:0] pa, logic [3:0] pb);
    bit ba, bb;
    ba = pa > band_lo && pa <= band_hi;
    bb = pb > band_lo && pb <= band_hi;
    return (ba && bb) || pa >= pb;
  endfunction

  task automatic push_word(logic [2:0] k, logic [15:0] t, logic [2:0] c,
                           logic [3:0] p, logic [1:0] a);
    focus_word_t w;
    w = '0;
    w.kind = k; w.target = t; w.code = c; w.bpol = p; w.ans = a;
    batch = {batch, w};
  endtask

  task automatic push_bcast(logic [3:0] p);
    push_word(RK_BROADCAST, 0, 0, p, 0);
    batch[$].skv = dk_v;
    batch[$].skid = dk_v ? dk_id : 16'd0;
  endtask

  task automatic drop_stream(logic [15:0] id);
    int w;
    w = 0;
    for (int r = 0; r < st_cnt; r++)
      if (st_id[r] != id) begin
        st_id[w] = st_id[r]; st_pol[w] = st_pol[r]; st_kind[w] = st_kind[r];
        w++;
      end
    st_cnt = w;
    if (dk_v && dk_id == id) dk_v = 0;
  endtask

  function automatic bit place(int pos, logic [15:0] id, logic [3:0] p, logic [1:0] k);
    bit full;
    int top;
    full = st_cnt >= DEPTH;
    if (full && pos >= DEPTH) return 1;
    top = full ? DEPTH - 1 : st_cnt;
    for (int i = top; i > pos; i--) begin
      st_id[i] = st_id[i-1]; st_pol[i] = st_pol[i-1]; st_kind[i] = st_kind[i-1];
    end
    st_id[pos] = id; st_pol[pos] = p; st_kind[pos] = k;
    if (!full) st_cnt++;
    return full;
  endfunction

  task automatic predict_focus(focus_req_t r);
    bit ovf;
    int i;
    logic [15:0] head;
    logic [1:0] fk;
    logic [2:0] lc;
    ovf = 0;
    batch.delete();
    if (r.cmd <= CMD_GAIN_DUCK) begin
      lc = (r.cmd == CMD_GAIN_TRANS) ? CC_LOSS_TRANS : CC_LOSS;
      if (st_cnt > 0 && st_id[0] == r.id) begin
      end else if (st_cnt == 0) begin
        void'(place(0, r.id, r.pol, r.cmd[1:0]));
        push_word(RK_NOTIFY, r.id, r.cmd, 0, 0);
      end else begin
        drop_stream(r.id);
        if (tie_or_beat(r.pol, st_pol[0])) begin
          head = st_id[0];
          if (!dk_v) begin
            if (r.cmd == CMD_GAIN_DUCK) begin
              push_word(RK_NOTIFY, head, CC_LOSS_DUCK, 0, 0);
              dk_v = 1; dk_id = head;
            end else push_word(RK_NOTIFY, head, lc, 0, 0);
          end else if (r.cmd == CMD_GAIN_DUCK) begin
            push_word(RK_NOTIFY, head, CC_LOSS_TRANS, 0, 0);
          end else begin
            push_word(RK_NOTIFY, head, lc, 0, 0);
            push_word(RK_NOTIFY, dk_id, CC_LOSS, 0, 0);
            dk_v = 0;
          end
          ovf = place(0, r.id, r.pol, r.cmd[1:0]);
          push_bcast(r.pol);
          push_word(RK_NOTIFY, r.id, r.cmd, 0, 0);
        end else begin
          for (i = 1; i < st_cnt; i++)
            if (tie_or_beat(r.pol, st_pol[i])) break;
          ovf = place(i, r.id, r.pol, r.cmd[1:0]);
        end
      end
    end else if (r.cmd == CMD_ABANDON) begin
      if (st_cnt > 0 && st_id[0] == r.id) begin
        for (i = 1; i < st_cnt; i++) begin
          st_id[i-1] = st_id[i]; st_pol[i-1] = st_pol[i]; st_kind[i-1] = st_kind[i];
        end
        st_cnt--;
        if (st_cnt > 0) begin
          fk = st_kind[0];
          if (!dk_v) push_word(RK_NOTIFY, st_id[0], fk, 0, 0);
          else if (st_id[0] == dk_id) begin
            push_word(RK_NOTIFY, st_id[0], fk, 0, 0);
            dk_v = 0;
          end else begin
            if (fk != KIND_DUCK) begin
              push_word(RK_NOTIFY, dk_id, CC_LOSS, 0, 0);
              dk_v = 0;
            end
            push_bcast(r.pol);
            push_word(RK_NOTIFY, st_id[0], fk, 0, 0);
          end
        end
      end else drop_stream(r.id);
    end else if (r.cmd == CMD_Q_STATE) begin
      logic [1:0] a;
      a = ANS_RELEASED;
      if (st_cnt > 0) begin
        if (st_id[0] == r.id) a = ANS_ACQUIRED;
        else if (dk_v && dk_id == r.id) a = ANS_DUCKED;
      end
      push_word(RK_STATE, 0, 0, 0, a);
    end else if (r.cmd == CMD_Q_CURRENT) begin
      if (st_cnt == 0) push_word(RK_CURRENT, 0, 0, idle_pol, 0);
      else push_word(RK_CURRENT, st_id[0], 0, st_pol[0], 0);
    end
    if (batch.size() == 0) push_word(RK_DONE, 0, 0, 0, 0);
    if (ovf) ovf_seen++;
    foreach (batch[k]) begin
      batch[k].ovf = ovf;
      batch[k].last = (k == batch.size() - 1);
      expected_q = {expected_q, batch[k]};
    end
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_focus(pending_q[0]);
        pending_q.delete(0);
        accepted++;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // now and then hold back until every result word is in
        if ($urandom_range(0, 7) == 0) drain_wait = 1;
      end
      if (drain_wait && expected_q.size() == 0) drain_wait = 0;
      if (in_valid && in_stall) begin
      end else if (gap > 0 || drv_pause || drain_wait || pending_q.size() == 0) begin
        in_valid <= 0;
        if (gap > 0) gap--;
      end else begin
        in_valid <= 1;
        in_command <= pending_q[0].cmd;
        in_stream_id <= pending_q[0].id;
        in_stream_policy <= pending_q[0].pol;
      end
    end
  end

  // monitor
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        focus_word_t e;
        words_seen++;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          if (out_result_kind !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, out_result_kind); errors++; end
          if (out_target_id !== e.target) begin
            $error("target_id exp %0h got %0h", e.target, out_target_id); errors++; end
          if (out_change_code !== e.code) begin
            $error("change_code exp %0d got %0d", e.code, out_change_code); errors++; end
          if (out_broadcast_policy !== e.bpol) begin
            $error("broadcast_policy exp %0d got %0d", e.bpol, out_broadcast_policy);
            errors++; end
          if (out_skip_valid !== e.skv) begin
            $error("skip_valid exp %0d got %0d", e.skv, out_skip_valid); errors++; end
          if (out_skip_id !== e.skid) begin
            $error("skip_id exp %0h got %0h", e.skid, out_skip_id); errors++; end
          if (out_focus_answer !== e.ans) begin
            $error("focus_answer exp %0d got %0d", e.ans, out_focus_answer); errors++; end
          if (out_overflow !== e.ovf) begin
            $error("overflow exp %0d got %0d", e.ovf, out_overflow); errors++; end
          if (out_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_last); errors++; end
        end
      end
      if (hold_long > 0) begin
        out_stall <= 1;
        hold_long--;
      end else if (stall_cnt > 0) begin
        out_stall <= 1;
        stall_cnt--;
      end else begin
        out_stall <= 0;
        if (out_valid && !out_stall && $urandom_range(0, 2) == 0)
          stall_cnt = $urandom_range(0, 12);
      end
    end
  end

  task automatic idle_wait();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_BAND_LOW:  band_lo = val;
      REG_BAND_HIGH: band_hi = val;
      default:       idle_pol = val;
    endcase
  endtask

  function automatic focus_req_t mk(logic [2:0] c, logic [15:0] i, logic [3:0] p);
    focus_req_t r;
    r.cmd = c; r.id = i; r.pol = p;
    return r;
  endfunction

  task automatic queue_req(focus_req_t r);
    pending_q = {pending_q, r};
  endtask

  // small id pool so that abandons and queries hit live entries
  task automatic add_random(int n);
    logic [15:0] pool [6];
    int c;
    for (int k = 0; k < 6; k++) pool[k] = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      c = $urandom_range(0, 9);
      if (c > 5) c = $urandom_range(0, 2);
      if ($urandom_range(0, 30) == 0) c = $urandom_range(6, 7);
      queue_req(mk(3'(c), $urandom_range(0, 7) == 0 ? 16'($urandom)
                          : pool[$urandom_range(0, 5)], 4'($urandom_range(0, 15))));
    end
  endtask

  initial begin
    st_cnt = 0; dk_v = 0; dk_id = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // directed
    queue_req(mk(CMD_Q_CURRENT, 0, 0));
    queue_req(mk(CMD_Q_STATE, 16'hFFFF, 0));
    queue_req(mk(CMD_ABANDON, 16'h1234, 0));
    queue_req(mk(CMD_GAIN, 16'h0000, 4'd0));
    queue_req(mk(CMD_GAIN, 16'h0000, 4'd15));
    queue_req(mk(CMD_GAIN_DUCK, 16'hFFFF, 4'd15));
    queue_req(mk(CMD_Q_STATE, 16'h0000, 0));
    queue_req(mk(CMD_GAIN_TRANS, 16'h00AA, 4'd15));
    queue_req(mk(CMD_GAIN_DUCK, 16'h0055, 4'd3));
    queue_req(mk(CMD_GAIN, 16'h0101, 4'd4));
    queue_req(mk(CMD_Q_CURRENT, 0, 0));
    queue_req(mk(CMD_ABANDON, 16'h0101, 4'd9));
    queue_req(mk(3'd6, 16'hAAAA, 4'd5));
    queue_req(mk(3'd7, 16'h5555, 4'd10));
    for (int k = 0; k < 9; k++) queue_req(mk(CMD_GAIN, 16'(16'h0200 + k), 4'd0));
    queue_req(mk(CMD_ABANDON, 16'h0055, 4'd1));
    idle_wait();
    // long receiver hold while the sender keeps offering
    hold_long = 60;
    add_random(10);
    idle_wait();
    write_reg(REG_BAND_LOW, 4'd15);
    write_reg(REG_BAND_HIGH, 4'd0);
    write_reg(REG_IDLE_POL, 4'd15);
    add_random(42);
    idle_wait();
    write_reg(REG_BAND_LOW, 4'd0);
    write_reg(REG_BAND_HIGH, 4'd15);
    write_reg(REG_IDLE_POL, 4'd0);
    add_random(42);
    idle_wait();
    write_reg(REG_BAND_LOW, 4'd3);
    write_reg(REG_BAND_HIGH, 4'd9);
    drv_pause = 1;
    add_random(42);
    repeat (200) @(posedge clk);
    drv_pause = 0;
    idle_wait();
    $display("%0d commands, %0d result words, %0d overflowing, band settings 4",
             accepted, words_seen, ovf_seen);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

### audio_focus_priority_arbiter_top.f
rtl/afpa_pkg.sv
rtl/afpa_cell.sv
rtl/audio_focus_priority_arbiter_top.sv
bench/audio_focus_priority_arbiter_top_test.sv
